// ===== design/ntsp_pkg.sv =====
// ntsp_pkg: widths, constants and controller/datapath command and status types
// for the note to sound pitch converter
// no dependencies
package ntsp_pkg;

  localparam int NOTE_W  = 7;   // note number and fine tune fields
  localparam int TUNE_W  = 14;  // note*128 + fine tune
  localparam int OCT_W   = 4;   // octave count, at most eleven
  localparam int BASE_W  = 16;  // base pitch after the 16-bit mask
  localparam int SCALE_W = 14;  // scale factor, stays below 2x of 0x1000 plus margin
  localparam int STEP_W  = 13;  // width of the per-step factor
  localparam int PROD_W  = BASE_W + SCALE_W;
  localparam int FRAC_W  = 5;
  localparam int STEPS_W = 6;
  localparam int DIFF_W  = PROD_W - FRAC_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int PITCH_W = 14;

  localparam logic [TUNE_W-1:0]  OCTAVE_UNITS = TUNE_W'(1536);
  localparam logic [BASE_W-1:0]  UNITY_PITCH  = 16'h1000;
  localparam logic [SCALE_W-1:0] UNIT_SCALE   = 14'h1000;
  localparam logic [STEP_W-1:0]  STEP_FACTOR  = 13'h103B;
  localparam logic [PITCH_W-1:0] PITCH_MAX    = 14'h3FFF;

  typedef struct packed {
    logic load;        // capture inputs, form distance and sign
    logic div_step;    // take one octave off the remainder
    logic adjust;      // fold a negative distance onto the lower octave
    logic base_ld;     // form base pitch, load step counter and scales
    logic scale_step;  // one truncated scale multiplication
    logic mul_lo;
    logic mul_hi;
    logic diff;
    logic mul_frac;
    logic out_ld;      // saturate and load the output register
  } cmd_t;

  typedef struct packed {
    logic rem_ge;      // remainder still holds a full octave
    logic steps_zero;  // no scale steps left
  } sts_t;

endpackage

// ===== design/ntsp_datapath.sv =====
// ntsp_datapath: octave split, base pitch, scale loop and interpolation registers
// depends on ntsp_pkg
module ntsp_datapath (
  input  logic                         clk,
  input  ntsp_pkg::cmd_t               cmd,
  output ntsp_pkg::sts_t               sts,
  input  logic [ntsp_pkg::NOTE_W-1:0]  center_note_num,
  input  logic [ntsp_pkg::NOTE_W-1:0]  center_fine_tune,
  input  logic [ntsp_pkg::NOTE_W-1:0]  note_num,
  input  logic [ntsp_pkg::NOTE_W-1:0]  fine_tune,
  output logic [ntsp_pkg::PITCH_W-1:0] pitch_word
);

  logic [ntsp_pkg::TUNE_W-1:0]  center, target;
  logic [ntsp_pkg::TUNE_W-1:0]  rem_r;
  logic [ntsp_pkg::OCT_W-1:0]   octs_r;
  logic                         neg_r;
  logic [ntsp_pkg::BASE_W-1:0]  base_r;
  logic [ntsp_pkg::STEPS_W-1:0] steps_r;
  logic [ntsp_pkg::SCALE_W-1:0] scale_r, prev_r;
  logic [ntsp_pkg::PROD_W-1:0]  lo_r, hi_r, term_r;
  logic [ntsp_pkg::DIFF_W-1:0]  diff_r;
  logic [ntsp_pkg::PITCH_W-1:0] pitch_r;
  logic [ntsp_pkg::PROD_W-1:0]  diff_full;
  logic [ntsp_pkg::SUM_W-1:0]   sum;
  logic [ntsp_pkg::SCALE_W+ntsp_pkg::STEP_W-1:0] scale_prod;

  assign center = {center_note_num, center_fine_tune};
  assign target = {note_num, fine_tune};

  assign scale_prod = (ntsp_pkg::SCALE_W + ntsp_pkg::STEP_W)'(scale_r)
                    * (ntsp_pkg::SCALE_W + ntsp_pkg::STEP_W)'(ntsp_pkg::STEP_FACTOR);
  assign diff_full  = hi_r - lo_r;
  assign sum        = ntsp_pkg::SUM_W'(lo_r) + ntsp_pkg::SUM_W'(term_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r  <= target < center;
      rem_r  <= (target < center) ? (center - target) : (target - center);
      octs_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= rem_r - ntsp_pkg::OCTAVE_UNITS;
      octs_r <= octs_r + 1'b1;
    end
    if (cmd.adjust && neg_r && (rem_r != '0)) begin
      rem_r  <= ntsp_pkg::OCTAVE_UNITS - rem_r;
      octs_r <= octs_r + 1'b1;
    end
    if (cmd.base_ld) begin
      // shifting up four or more octaves leaves nothing in 16 bits
      base_r  <= neg_r ? (ntsp_pkg::UNITY_PITCH >> octs_r) : (ntsp_pkg::UNITY_PITCH << octs_r);
      steps_r <= rem_r[ntsp_pkg::FRAC_W +: ntsp_pkg::STEPS_W];
      prev_r  <= ntsp_pkg::UNIT_SCALE;
      scale_r <= ntsp_pkg::SCALE_W'(ntsp_pkg::STEP_FACTOR);
    end
    if (cmd.scale_step) begin
      prev_r  <= scale_r;
      scale_r <= scale_prod[12 +: ntsp_pkg::SCALE_W];
      steps_r <= steps_r - 1'b1;
    end
    if (cmd.mul_lo) begin
      lo_r <= ntsp_pkg::PROD_W'(base_r) * ntsp_pkg::PROD_W'(prev_r);
    end
    if (cmd.mul_hi) begin
      hi_r <= ntsp_pkg::PROD_W'(base_r) * ntsp_pkg::PROD_W'(scale_r);
    end
    if (cmd.diff) begin
      diff_r <= diff_full[ntsp_pkg::FRAC_W +: ntsp_pkg::DIFF_W];
    end
    if (cmd.mul_frac) begin
      term_r <= ntsp_pkg::PROD_W'(diff_r) * ntsp_pkg::PROD_W'(rem_r[ntsp_pkg::FRAC_W-1:0]);
    end
    if (cmd.out_ld) begin
      // saturate anything at or above 0x4000 after the shift
      pitch_r <= (sum[ntsp_pkg::SUM_W-1:12+ntsp_pkg::PITCH_W] != '0)
                 ? ntsp_pkg::PITCH_MAX : sum[12 +: ntsp_pkg::PITCH_W];
    end
  end

  assign sts.rem_ge     = rem_r >= ntsp_pkg::OCTAVE_UNITS;
  assign sts.steps_zero = steps_r == '0;
  assign pitch_word     = pitch_r;

endmodule

// ===== design/ntsp_ctrl.sv =====
// ntsp_ctrl: sequencing state machine and handshake control
// depends on ntsp_pkg
module ntsp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output ntsp_pkg::cmd_t cmd,
  input  ntsp_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_ADJ, S_BASE, S_SCALE, S_MLO, S_MHI, S_DIFF, S_MFRAC, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.rem_ge) cmd.div_step = 1'b1;
        else state_nxt = S_ADJ;
      end
      S_ADJ: begin
        cmd.adjust = 1'b1;
        state_nxt  = S_BASE;
      end
      S_BASE: begin
        cmd.base_ld = 1'b1;
        state_nxt   = S_SCALE;
      end
      S_SCALE: begin
        if (sts.steps_zero) state_nxt = S_MLO;
        else cmd.scale_step = 1'b1;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MFRAC;
      end
      S_MFRAC: begin
        cmd.mul_frac = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

// ===== design/note_to_sound_pitch.sv =====
// note_to_sound_pitch: top level, note and fine tune to 14-bit sound pitch word
// depends on ntsp_pkg, ntsp_ctrl, ntsp_datapath
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   center_note_num, center_fine_tune,
//                                             note_num, fine_tune (7 bits each)
//   out_     output     out_valid / out_stall out_pitch_word (14 bits)
//
// one transaction at a time: the work for a transaction grows with its octaves
// (up to 10), which come from the repeated subtract of 1536, and its steps (up to 47),
// which run through the single scale multiplier loop
// rst_n is synchronous and active low; it clears the controller and the output valid
// a finished result waits in the output register while the next transaction is taken
// out_stall only holds the controller in its final state when that register is still full
module note_to_sound_pitch (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ntsp_pkg::NOTE_W-1:0]  in_center_note_num,
  input  logic [ntsp_pkg::NOTE_W-1:0]  in_center_fine_tune,
  input  logic [ntsp_pkg::NOTE_W-1:0]  in_note_num,
  input  logic [ntsp_pkg::NOTE_W-1:0]  in_fine_tune,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ntsp_pkg::PITCH_W-1:0] out_pitch_word
);

  ntsp_pkg::cmd_t cmd;  // controller to datapath
  ntsp_pkg::sts_t sts;  // datapath to controller

  // sequencing and both handshakes
  ntsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // inputs are sampled only in the accept cycle, so they need no holding register
  ntsp_datapath u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .center_note_num  (in_center_note_num),
    .center_fine_tune (in_center_fine_tune),
    .note_num         (in_note_num),
    .fine_tune        (in_fine_tune),
    .pitch_word       (out_pitch_word)
  );

endmodule

// ===== design/ntsp_checker.sv =====
// ntsp_checker: port-level assertions for note_to_sound_pitch, with its bind
// depends on ntsp_pkg and the note_to_sound_pitch ports
module ntsp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ntsp_pkg::PITCH_W-1:0] out_pitch_word
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pitch_word))
    else $error("result changed or dropped while stalled");

  // an accepted transaction keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transaction was accepted");

  // a new result only appears at the end of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // leaving the busy period always leaves a result behind
  a_work_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) && $past(rst_n) |-> out_valid)
    else $error("busy period ended without a result");

endmodule

bind note_to_sound_pitch ntsp_checker u_ntsp_checker (.*);
